// ===== sv/dpd_pair_force_unit_macros.svh =====
// Assertion macros shared by the pair force RTL.
`ifndef DPD_PAIR_FORCE_UNIT_MACROS_SVH
`define DPD_PAIR_FORCE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPD_ASSERT_IMP(lbl, ante, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPD_ASSERT_NXT(lbl, ante, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/dpd_pkg.sv =====
// Types, constants and saturation helpers for the pair force unit.
package dpd_pkg;

  localparam logic [16:0] ONE_Q    = 17'd65536;
  localparam logic [46:0] WIDE_MAX = 47'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REG_CUTOFF      = 2'd0,
    REG_THERMAL     = 2'd1,
    REG_INV_SQRT_DT = 2'd2
  } cfg_reg_t;

  // Pair data carried alongside the root and divide pipelines.
  typedef struct packed {
    logic             hit;
    logic [30:0]      cut;
    logic [2:0]       dneg;
    logic [2:0][31:0] dmag;
    logic [2:0][31:0] dv;
    logic [30:0]      a;
    logic [30:0]      gam;
    logic [31:0]      alpha;
    logic [30:0]      mi;
    logic [30:0]      mj;
  } pair_t;

  // Pair data carried through the force arithmetic.
  typedef struct packed {
    logic             hit;
    logic [2:0]       eneg;
    logic [2:0][16:0] emag;
    logic [30:0]      gam;
    logic             aneg;
    logic [31:0]      amag;
    logic [30:0]      mi;
    logic [30:0]      mj;
  } mid_t;

  function automatic logic signed [48:0] sat_w(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = $signed({3'b000, WIDE_MAX});
    lo = -hi;
    if (v > hi) return 49'(hi);
    else if (v < lo) return 49'(lo);
    else return 49'(v);
  endfunction

  function automatic logic [46:0] sat47(input logic [62:0] m);
    if (m > 63'(WIDE_MAX)) return WIDE_MAX;
    else return m[46:0];
  endfunction

  // Sign and magnitude to a saturated signed 32-bit word.
  function automatic logic [31:0] clamp32(input logic neg, input logic [62:0] mag);
    if (neg) begin
      if (mag >= 63'h8000_0000) return 32'h8000_0000;
      else return -mag[31:0];
    end else begin
      if (mag > 63'h7FFF_FFFF) return 32'h7FFF_FFFF;
      else return mag[31:0];
    end
  endfunction

endpackage

// ===== sv/dpd_pair_force_unit.sv =====
// Dissipative particle dynamics pair force unit (top level).
//
// One pair transaction in, one result transaction out, one pair per clock
// sustained while results are taken. Input to m_tvalid passes through two
// front stages (squares, then r^2 sum and cutoff test), a 32-stage square
// root that yields r and the noise amplitude sigma side by side, a 17-stage
// divider bank giving the unit vector and r/cutoff, and eight arithmetic
// stages for the conservative, dissipative and random terms and the two
// mass scalings. The whole pipeline advances together and holds only when
// the output register carries a result that is not taken; bubbles pass
// freely. Out-of-range or zero-distance pairs return zero accelerations
// with in_range (m_tuser) low. Config writes are expected while idle.
`include "dpd_pair_force_unit_macros.svh"

module dpd_pair_force_unit
  import dpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  // pair input
  input  logic         s_tvalid,
  output logic         s_tready,
  // delta_x, delta_y, delta_z, vel_diff_x, vel_diff_y, vel_diff_z,
  // conservative_coef, dissipative_coef, gaussian_sample,
  // inv_mass_first, inv_mass_second, 4 pad bits
  input  logic [351:0] s_tdata,
  // result output
  output logic         m_tvalid,
  input  logic         m_tready,
  // accel_first_x/y/z, accel_second_x/y/z
  output logic [191:0] m_tdata,
  // in_range
  output logic         m_tuser
);

  localparam int NST = 59;   // total register stages
  localparam int NSD = 50;   // side stages across root and divide
  localparam int RTS = 32;   // root stages

  // ---------------- configuration ----------------
  logic [30:0] cutoff, thermal, inv_sqrt_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff      <= 31'd65536;
      thermal     <= 31'd65536;
      inv_sqrt_dt <= 31'd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CUTOFF:      cutoff      <= cfg_data;
        REG_THERMAL:     thermal     <= cfg_data;
        REG_INV_SQRT_DT: inv_sqrt_dt <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] vld;
  logic           en;

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // ---------------- E1: squares ----------------
  logic [2:0][31:0] in_d, in_v, in_mag;
  logic [2:0][63:0] sq_c;
  pair_t            e1_c, e1_side;
  logic [2:0][63:0] e1_sq;
  logic [61:0]      e1_tg, e1_cc;

  always_comb begin
    e1_c = '0;
    for (int k = 0; k < 3; k++) begin
      in_d[k]      = s_tdata[32*k +: 32];
      in_v[k]      = s_tdata[96 + 32*k +: 32];
      in_mag[k]    = in_d[k][31] ? (~in_d[k] + 32'd1) : in_d[k];
      sq_c[k]      = 64'(in_mag[k]) * 64'(in_mag[k]);
      e1_c.dneg[k] = in_d[k][31];
      e1_c.dmag[k] = in_mag[k];
      e1_c.dv[k]   = in_v[k];
    end
    e1_c.cut   = cutoff;
    e1_c.a     = s_tdata[222:192];
    e1_c.gam   = s_tdata[253:223];
    e1_c.alpha = s_tdata[285:254];
    e1_c.mi    = s_tdata[316:286];
    e1_c.mj    = s_tdata[347:317];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_side <= e1_c;
      e1_sq   <= sq_c;
      e1_tg   <= 62'(thermal) * 62'(s_tdata[253:223]);
      e1_cc   <= 62'(cutoff) * 62'(cutoff);
    end
  end

  // ---------------- E2: r^2 and range test ----------------
  logic [63:0] rsq_c, e2_rsq, e2_sig;
  logic        hit_c;
  pair_t       e2_c;

  assign rsq_c = e1_sq[0] + e1_sq[1] + e1_sq[2];
  assign hit_c = (rsq_c != 64'd0) && (e1_side.cut != 31'd0) &&
                 (rsq_c <= 64'(e1_cc));

  // pair data with the range result folded in
  always_comb begin
    e2_c     = e1_side;
    e2_c.hit = hit_c;
  end

  pair_t side [0:NSD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      e2_rsq  <= rsq_c;
      e2_sig  <= {1'b0, e1_tg, 1'b0};
      side[0] <= e2_c;
      for (int i = 1; i < NSD; i++) side[i] <= side[i-1];
    end
  end

  // ---------------- square roots: r and sigma ----------------
  logic [31:0] r_root, sig_root;

  dpd_isqrt #(.RW(RTS)) u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .rad  (e2_rsq),
    .root (r_root)
  );

  dpd_isqrt #(.RW(RTS)) u_sqrt_sig (
    .clk  (clk),
    .en   (en),
    .rad  (e2_sig),
    .root (sig_root)
  );

  // ---------------- divides: unit vector and r/cutoff ----------------
  logic [2:0][16:0] qe;
  logic [16:0]      qw;
  logic [31:0]      sig_d [1:17];

  for (genvar k = 0; k < 3; k++) begin : g_unit
    dpd_div #(.NW(48), .DW(32), .QW(17)) u_div_e (
      .clk (clk),
      .en  (en),
      .num ({side[RTS].dmag[k], 16'd0}),
      .den (r_root),
      .quo (qe[k])
    );
  end

  dpd_div #(.NW(48), .DW(32), .QW(17)) u_div_w (
    .clk (clk),
    .en  (en),
    .num ({r_root, 16'd0}),
    .den ({1'b0, side[RTS].cut}),
    .quo (qw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sig_d[1] <= sig_root;
      for (int i = 2; i <= 17; i++) sig_d[i] <= sig_d[i-1];
    end
  end

  // ---------------- M1: weight and first products ----------------
  pair_t                   sd;
  logic [16:0]             w_c;
  logic signed [2:0][17:0] es_c;
  logic signed [49:0]      pd_c [3];
  mid_t                    m1_c, m1;
  logic signed [49:0]      m1_pd [3];
  logic [47:0]             m1_cons;
  logic [33:0]             m1_ww;
  logic [48:0]             m1_sw;

  assign sd  = side[NSD-1];
  assign w_c = ONE_Q - qw;

  always_comb begin
    m1_c = '0;
    for (int k = 0; k < 3; k++) begin
      es_c[k]      = sd.dneg[k] ? -$signed({1'b0, qe[k]}) : $signed({1'b0, qe[k]});
      pd_c[k]      = $signed(es_c[k]) * $signed(sd.dv[k]);
      m1_c.eneg[k] = sd.dneg[k];
      m1_c.emag[k] = qe[k];
    end
    m1_c.hit  = sd.hit;
    m1_c.gam  = sd.gam;
    m1_c.aneg = sd.alpha[31];
    m1_c.amag = sd.alpha[31] ? (~sd.alpha + 32'd1) : sd.alpha;
    m1_c.mi   = sd.mi;
    m1_c.mj   = sd.mj;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1      <= m1_c;
      m1_pd   <= pd_c;
      m1_cons <= 48'(sd.a) * 48'(w_c);
      m1_ww   <= 34'(w_c) * 34'(w_c);
      m1_sw   <= 49'(sig_d[17]) * 49'(w_c);
    end
  end

  // ---------------- M2: projection e.dv ----------------
  logic signed [51:0] proj_c;
  logic [51:0]        pabs_c;
  mid_t               m2;
  logic [35:0]        m2_pmag;
  logic               m2_pneg;
  logic [31:0]        m2_cons;
  logic [47:0]        m2_g2p;
  logic [63:0]        m2_rn1p;

  assign proj_c = 52'(m1_pd[0]) + 52'(m1_pd[1]) + 52'(m1_pd[2]);
  assign pabs_c = proj_c[51] ? 52'(-proj_c) : 52'(proj_c);

  always_ff @(posedge clk) begin
    if (en) begin
      m2      <= m1;
      m2_pmag <= pabs_c[51:16];
      m2_pneg <= proj_c[51];
      m2_cons <= m1_cons[47:16];
      m2_g2p  <= 48'(m1.gam) * 48'(m1_ww[32:16]);
      m2_rn1p <= 64'(m1_sw[47:16]) * 64'(m1.amag);
    end
  end

  // ---------------- M3: dissipative and random products ----------------
  logic [46:0] rn1_c;
  mid_t        m3;
  logic [66:0] m3_dprod;
  logic        m3_dneg;
  logic [53:0] m3_rph;
  logic [54:0] m3_rpl;
  logic [31:0] m3_cons;

  assign rn1_c = m2_rn1p[62:16];

  always_ff @(posedge clk) begin
    if (en) begin
      m3       <= m2;
      m3_dprod <= 67'(m2_g2p[46:16]) * 67'(m2_pmag);
      m3_dneg  <= m2_pneg;
      m3_rph   <= 54'(rn1_c[46:24]) * 54'(inv_sqrt_dt);
      m3_rpl   <= 55'(rn1_c[23:0]) * 55'(inv_sqrt_dt);
      m3_cons  <= m2_cons;
    end
  end

  // ---------------- M4: term saturation ----------------
  logic [46:0]        dsat_c, rsat_c;
  logic [78:0]        rtot_c;
  mid_t               m4;
  logic signed [48:0] m4_diss, m4_rnd;
  logic [31:0]        m4_cons;

  assign dsat_c = sat47(63'(m3_dprod[66:16]));
  assign rtot_c = {m3_rph, 24'd0} + 79'(m3_rpl);
  assign rsat_c = sat47(rtot_c[78:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      m4      <= m3;
      m4_diss <= m3_dneg ? -$signed({2'b00, dsat_c}) : $signed({2'b00, dsat_c});
      m4_rnd  <= m3.aneg ? -$signed({2'b00, rsat_c}) : $signed({2'b00, rsat_c});
      m4_cons <= m3_cons;
    end
  end

  // ---------------- M5: total scalar force ----------------
  logic signed [48:0] t_c, f_c;
  logic [48:0]        fabs_c;
  mid_t               m5;
  logic [46:0]        m5_fmag;
  logic               m5_fpos;

  assign t_c    = sat_w($signed({18'd0, m4_cons}) - 50'(m4_diss));
  assign f_c    = sat_w(50'(t_c) + 50'(m4_rnd));
  assign fabs_c = f_c[48] ? 49'(-f_c) : 49'(f_c);

  always_ff @(posedge clk) begin
    if (en) begin
      m5      <= m4;
      m5_fmag <= fabs_c[46:0];
      m5_fpos <= !f_c[48] && (f_c != '0);
    end
  end

  // ---------------- M6: force along the unit vector ----------------
  mid_t             m6;
  logic [2:0][63:0] m6_fp;
  logic [2:0]       m6_fneg;

  always_ff @(posedge clk) begin
    if (en) begin
      m6 <= m5;
      for (int k = 0; k < 3; k++) begin
        m6_fp[k]   <= 64'(m5_fmag) * 64'(m5.emag[k]);
        m6_fneg[k] <= m5_fpos ^ m5.eneg[k];
      end
    end
  end

  // ---------------- M7: mass scaling partial products ----------------
  logic [2:0][46:0] fi_c;
  logic             m7_hit;
  logic [2:0]       m7_fneg;
  logic [2:0][53:0] m7_ph1, m7_ph2;
  logic [2:0][54:0] m7_pl1, m7_pl2;

  always_comb begin
    for (int k = 0; k < 3; k++) fi_c[k] = m6_fp[k][62:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m7_hit  <= m6.hit;
      m7_fneg <= m6_fneg;
      for (int k = 0; k < 3; k++) begin
        m7_ph1[k] <= 54'(fi_c[k][46:24]) * 54'(m6.mi);
        m7_pl1[k] <= 55'(fi_c[k][23:0]) * 55'(m6.mi);
        m7_ph2[k] <= 54'(fi_c[k][46:24]) * 54'(m6.mj);
        m7_pl2[k] <= 55'(fi_c[k][23:0]) * 55'(m6.mj);
      end
    end
  end

  // ---------------- M8: output register ----------------
  logic [2:0][78:0] t1_c, t2_c;
  logic [191:0]     out_c;

  always_comb begin
    out_c = '0;
    for (int k = 0; k < 3; k++) begin
      t1_c[k] = {m7_ph1[k], 24'd0} + 79'(m7_pl1[k]);
      t2_c[k] = {m7_ph2[k], 24'd0} + 79'(m7_pl2[k]);
      if (m7_hit) begin
        out_c[32*k +: 32]      = clamp32(m7_fneg[k], t1_c[k][78:16]);
        out_c[96 + 32*k +: 32] = clamp32(!m7_fneg[k], t2_c[k][78:16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= out_c;
      m_tuser <= m7_hit;
    end
  end

  // ---------------- checks ----------------
  `DPD_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss gave nonzero accel")
  `DPD_ASSERT_IMP(a_stall_src, !s_tready, m_tvalid && !m_tready, "stall without backpressure")
  `DPD_ASSERT_IMP(a_w_bound, vld[NSD] && sd.hit, qw <= ONE_Q, "r over cutoff above one")
  `DPD_ASSERT_NXT(a_root_hold, !en, $stable(r_root), "root moved during stall")

endmodule

// ===== sv/dpd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module dpd_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int XW = 2*RW + 2;

  logic [XW-1:0] rem [1:RW-1];
  logic [RW-1:0] acc [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_st
    localparam int B = RW - 1 - i;
    logic [XW-1:0] r_in;
    logic [RW-1:0] q_in;
    logic [XW-1:0] trial;
    logic          take;

    if (i == 0) begin : g_first
      assign r_in = XW'(rad);
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[i];
      assign q_in = acc[i];
    end

    // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
    assign trial = (XW'(q_in) << (B + 1)) + (XW'(1) << (2*B));
    assign take  = r_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= take ? (q_in | (RW'(1) << B)) : q_in;
      end
    end

    if (i < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? (r_in - trial) : r_in;
        end
      end
    end
  end

  assign root = acc[RW];

endmodule

// ===== sv/dpd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dpd_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = DW + QW;

  logic [CW-1:0] rem [1:QW-1];
  logic [DW-1:0] dvs [1:QW-1];
  logic [QW-1:0] acc [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    localparam int B = QW - 1 - i;
    logic [CW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [CW-1:0] sub;
    logic          take;

    if (i == 0) begin : g_first
      assign r_in = CW'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[i];
      assign d_in = dvs[i];
      assign q_in = acc[i];
    end

    assign sub  = CW'(d_in) << B;
    assign take = r_in >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i+1] <= take ? (q_in | (QW'(1) << B)) : q_in;
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? (r_in - sub) : r_in;
          dvs[i+1] <= d_in;
        end
      end
    end
  end

  assign quo = acc[QW];

endmodule
